// ===== hdl/bcr_pkg.sv =====
package bcr_pkg;

  localparam int ROW_WORD  = 64;
  localparam int FRAC_WORD = 16;
  localparam int OUT_WORD  = 16;
  localparam int NUM_TAPS  = 4;
  localparam int NUM_LANES = 4;
  localparam int CUBIC_LAT = 6;

  typedef struct packed {
    logic [ROW_WORD-1:0]  row_0;
    logic [ROW_WORD-1:0]  row_1;
    logic [ROW_WORD-1:0]  row_2;
    logic [ROW_WORD-1:0]  row_3;
    logic [FRAC_WORD-1:0] frac_x;
    logic [FRAC_WORD-1:0] frac_y;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_WORD-1:0] value;
    logic                       saturated;
  } out_item_t;

endpackage

// ===== hdl/bicubic_catmull_rom_interpolator_top.sv =====
// An accepted start passes the row lanes, merge lane and output register to out_valid.
// Throughput: one item per cycle; busy is never raised.
// Four row lanes and one merge lane, six pipeline stages each, then one output register.
// Reset: synchronous, active low; clears the valid pipeline only, data registers are not reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bicubic_catmull_rom_interpolator_top #(
  parameter int SAMPLE_BITS = 16,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bcr_pkg::in_item_t  in_item,
  output logic               out_valid,
  output bcr_pkg::out_item_t out_item
);
  import bcr_pkg::*;

  localparam int ROW_BITS = SAMPLE_BITS + 4;
  localparam int LRW      = SAMPLE_BITS + 8;
  localparam int MRW      = ROW_BITS + 8;
  localparam int LAT      = 2 * CUBIC_LAT + 1;

  localparam logic signed [LRW-1:0] ROW_HI = LRW'((64'sd1 <<< (ROW_BITS - 1)) - 64'sd1);
  localparam logic signed [LRW-1:0] ROW_LO = LRW'(-(64'sd1 <<< (ROW_BITS - 1)));
  localparam logic signed [MRW-1:0] FIN_HI = MRW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [MRW-1:0] FIN_LO = MRW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
  localparam logic signed [OUT_WORD-1:0] OUT_HI = OUT_WORD'(FIN_HI);
  localparam logic signed [OUT_WORD-1:0] OUT_LO = OUT_WORD'(FIN_LO);

  logic                          accept;
  logic [ROW_WORD-1:0]           rows [NUM_LANES];
  logic signed [SAMPLE_BITS-1:0] smp [NUM_LANES][NUM_TAPS];
  logic [NUM_LANES-1:0]          lane_vld;
  logic signed [LRW-1:0]         lane_res [NUM_LANES];
  logic signed [ROW_BITS-1:0]    col [NUM_LANES];
  logic [FRAC_BITS-1:0]          fx_dly_r [CUBIC_LAT];
  logic                          merge_vld;
  logic signed [MRW-1:0]         merge_res;
  logic signed [SAMPLE_BITS-1:0] fin_clip;
  logic                          fin_sat;
  logic                          out_valid_r;
  out_item_t                     out_item_r;
  out_item_t                     out_item_nxt;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    rows[0] = in_item.row_0;
    rows[1] = in_item.row_1;
    rows[2] = in_item.row_2;
    rows[3] = in_item.row_3;
    for (int r = 0; r < NUM_LANES; r++) begin
      for (int i = 0; i < NUM_TAPS; i++) begin
        smp[r][i] = $signed(rows[r][i*SAMPLE_BITS +: SAMPLE_BITS]);
      end
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bcr_cubic #(
      .W (SAMPLE_BITS),
      .F (FRAC_BITS)
    ) u_row (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (accept),
      .in_p      (smp[g]),
      .in_frac   (in_item.frac_y[FRAC_BITS-1:0]),
      .out_valid (lane_vld[g]),
      .out_res   (lane_res[g])
    );

    always_comb begin
      if (lane_res[g] > ROW_HI) begin
        col[g] = ROW_BITS'(ROW_HI);
      end else if (lane_res[g] < ROW_LO) begin
        col[g] = ROW_BITS'(ROW_LO);
      end else begin
        col[g] = ROW_BITS'(lane_res[g]);
      end
    end
  end

  always_ff @(posedge clk) begin
    fx_dly_r[0] <= in_item.frac_x[FRAC_BITS-1:0];
    for (int k = 1; k < CUBIC_LAT; k++) begin
      fx_dly_r[k] <= fx_dly_r[k-1];
    end
  end

  bcr_cubic #(
    .W (ROW_BITS),
    .F (FRAC_BITS)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (&lane_vld),
    .in_p      (col),
    .in_frac   (fx_dly_r[CUBIC_LAT-1]),
    .out_valid (merge_vld),
    .out_res   (merge_res)
  );

  always_comb begin
    fin_sat = 1'b1;
    if (merge_res > FIN_HI) begin
      fin_clip = SAMPLE_BITS'(FIN_HI);
    end else if (merge_res < FIN_LO) begin
      fin_clip = SAMPLE_BITS'(FIN_LO);
    end else begin
      fin_clip = SAMPLE_BITS'(merge_res);
      fin_sat  = 1'b0;
    end
    out_item_nxt.value     = OUT_WORD'(fin_clip);
    out_item_nxt.saturated = fin_sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= merge_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_vld) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_start_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LAT out_valid)
    else $error("accepted item produced no result");

  a_out_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LAT))
    else $error("result without an accepted item");

  a_sat_at_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.saturated) |-> (out_item.value == OUT_HI || out_item.value == OUT_LO))
    else $error("saturated flag set but value not at range limit");

  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    lane_vld[0] |-> (&lane_vld))
    else $error("row lanes out of step");

endmodule

// ===== hdl/bcr_cubic.sv =====
module bcr_cubic #(
  parameter int W = 16,
  parameter int F = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   in_p [bcr_pkg::NUM_TAPS],
  input  logic        [F-1:0]   in_frac,
  output logic                  out_valid,
  output logic signed [W+7:0]   out_res
);
  import bcr_pkg::*;

  localparam int AW  = W + 1;
  localparam int BW  = W + 4;
  localparam int CW  = W + 3;
  localparam int FW  = F + 1;
  localparam int S1W = W + F + 5;
  localparam int M2W = S1W + FW;
  localparam int S2W = W + F + 7;
  localparam int M3W = S2W + FW;
  localparam int RSW = W + F + 9;
  localparam int RW  = W + 8;
  localparam logic signed [RSW-1:0] HALF = RSW'(1) <<< F;

  logic [CUBIC_LAT-1:0] vld_r;

  logic signed [AW-1:0]  a1_r, a2_r, a3_r;
  logic signed [BW-1:0]  b1_r;
  logic signed [CW-1:0]  c1_r;
  logic signed [W-1:0]   p1_1_r, p1_2_r, p1_3_r, p1_4_r, p1_5_r;
  logic signed [FW-1:0]  f1_r, f2_r, f3_r, f4_r;
  logic signed [S1W-1:0] s1_r;
  logic signed [M2W-1:0] m2_r;
  logic signed [S2W-1:0] s2_r;
  logic signed [M3W-1:0] m3_r;
  logic signed [RW-1:0]  res_r;

  logic signed [AW-1:0]  a_nxt;
  logic signed [BW-1:0]  b_nxt;
  logic signed [CW-1:0]  c_nxt;
  logic signed [S1W-1:0] s1_nxt;
  logic signed [M2W-1:0] m2_nxt;
  logic signed [S2W-1:0] s2_nxt;
  logic signed [M3W-1:0] m3_nxt;
  logic signed [RSW-1:0] sum_nxt;
  logic signed [RW-1:0]  res_nxt;
  logic signed [M2W-1:0] m2_sh;
  logic signed [M3W-1:0] m3_sh;

  always_comb begin
    a_nxt = AW'(in_p[2]) - AW'(in_p[0]);
    b_nxt = (BW'(in_p[0]) <<< 1) - (BW'(in_p[1]) <<< 2) - BW'(in_p[1])
          + (BW'(in_p[2]) <<< 2) - BW'(in_p[3]);
    c_nxt = CW'(in_p[3]) - CW'(in_p[0]) + (CW'(in_p[1]) <<< 1) + CW'(in_p[1])
          - (CW'(in_p[2]) <<< 1) - CW'(in_p[2]);
    s1_nxt = (S1W'(b1_r) <<< F) + S1W'(c1_r * f1_r);
    m2_nxt = s1_r * f2_r;
    m2_sh  = m2_r >>> F;
    s2_nxt = (S2W'(a3_r) <<< F) + S2W'(m2_sh);
    m3_nxt = s2_r * f4_r;
    m3_sh  = m3_r >>> F;
    sum_nxt = (RSW'(p1_5_r) <<< (F + 1)) + RSW'(m3_sh) + HALF;
    res_nxt = RW'(sum_nxt >>> (F + 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CUBIC_LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    a1_r   <= a_nxt;
    b1_r   <= b_nxt;
    c1_r   <= c_nxt;
    p1_1_r <= in_p[1];
    f1_r   <= $signed({1'b0, in_frac});

    s1_r   <= s1_nxt;
    a2_r   <= a1_r;
    p1_2_r <= p1_1_r;
    f2_r   <= f1_r;

    m2_r   <= m2_nxt;
    a3_r   <= a2_r;
    p1_3_r <= p1_2_r;
    f3_r   <= f2_r;

    s2_r   <= s2_nxt;
    p1_4_r <= p1_3_r;
    f4_r   <= f3_r;

    m3_r   <= m3_nxt;
    p1_5_r <= p1_4_r;

    res_r  <= res_nxt;
  end

  assign out_valid = vld_r[CUBIC_LAT-1];
  assign out_res   = res_r;

endmodule
